FILE: sv/des_key_schedule_defines.svh
// Assertion macros for the DES key schedule block.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef DES_KEY_SCHEDULE_DEFINES_SVH
`define DES_KEY_SCHEDULE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under reset.
`define DKS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define DKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DKS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define DKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/dks_pkg.sv
`timescale 1ns / 1ps

package dks_pkg;

    localparam int unsigned Rounds    = 16;
    localparam int unsigned HalfWidth = 28;
    localparam int unsigned KeyWidth  = 64;
    localparam int unsigned SubWidth  = 48;

    localparam logic [63:0] ParityMask = 64'hFEFE_FEFE_FEFE_FEFE;
    localparam logic [3:0]  LastRound  = 4'd15;

    // Two 28-bit key halves, C above D
    typedef struct packed {
        logic [HalfWidth-1:0] c;
        logic [HalfWidth-1:0] d;
    } cd_t;

    // Published PC-1 and PC-2 selections, position 1 is the MSB
    localparam int unsigned Pc1Sel [56] = '{
        57, 49, 41, 33, 25, 17, 9,
        1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27,
        19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,
        7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29,
        21, 13, 5, 28, 20, 12, 4
    };

    localparam int unsigned Pc2Sel [48] = '{
        14, 17, 11, 24, 1, 5,
        3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8,
        16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55,
        30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53,
        46, 42, 50, 36, 29, 32
    };

    // Mask parity and pick the 56 key bits
    function automatic cd_t pc1(input logic [KeyWidth-1:0] key);
        logic [KeyWidth-1:0] k;
        logic [2*HalfWidth-1:0] cd;
        k = key & ParityMask;
        for (int i = 0; i < 56; i++) begin
            cd[55-i] = k[KeyWidth-Pc1Sel[i]];
        end
        return cd;
    endfunction

    // Pick the 48 subkey bits from C:D
    function automatic logic [SubWidth-1:0] pc2(input cd_t cd);
        logic [2*HalfWidth-1:0] v;
        logic [SubWidth-1:0] sub;
        v = cd;
        for (int i = 0; i < 48; i++) begin
            sub[47-i] = v[56-Pc2Sel[i]];
        end
        return sub;
    endfunction

    // Rounds 1, 2, 9 and 16 rotate by one, the rest by two
    function automatic logic rot_by_two(input logic [3:0] round);
        logic two;
        case (round)
            4'd0, 4'd1, 4'd8, 4'd15: two = 1'b0;
            default:                 two = 1'b1;
        endcase
        return two;
    endfunction

    function automatic logic [HalfWidth-1:0] rot_half(input logic [HalfWidth-1:0] h,
                                                      input logic two);
        logic [HalfWidth-1:0] r;
        r = two ? {h[HalfWidth-3:0], h[HalfWidth-1:HalfWidth-2]}
                : {h[HalfWidth-2:0], h[HalfWidth-1]};
        return r;
    endfunction

endpackage

FILE: sv/dks_front.sv
`timescale 1ns / 1ps

module dks_front (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [63:0]  s_key,
    output logic         push_valid,
    input  logic         push_ready,
    output dks_pkg::cd_t push_cd
);
    import dks_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cd_t  hold_cd_reg;

    // Take a key when the stage is empty or drains this cycle
    assign s_ready = !hold_valid_reg || push_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Register the halves after PC-1
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_cd_reg <= pc1(s_key);
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_cd    = hold_cd_reg;

endmodule

FILE: sv/dks_queue.sv
`timescale 1ns / 1ps

`include "des_key_schedule_defines.svh"

module dks_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  dks_pkg::cd_t in_cd,
    output logic         out_valid,
    input  logic         out_ready,
    output dks_pkg::cd_t out_cd
);
    import dks_pkg::*;

    cd_t        mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cd    = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_cd;
        end
    end

    `DKS_ASSERT_SAME(a_q_count_range, aclk, aresetn, 1'b1, count_reg != 2'd3, "queue count out of range")
    `DKS_ASSERT_SAME(a_q_ptrs_full, aclk, aresetn, count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg, "queue pointers disagree when full")

endmodule

FILE: sv/dks_back.sv
`timescale 1ns / 1ps

`include "des_key_schedule_defines.svh"

module dks_back (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    output logic         q_ready,
    input  dks_pkg::cd_t q_cd,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [47:0]  m_subkey,
    output logic [3:0]   m_round_index,
    output logic         m_last
);
    import dks_pkg::*;

    logic        busy_reg;
    logic        busy_next;
    logic [3:0]  round_reg;
    logic [3:0]  round_next;
    cd_t         cd_reg;
    cd_t         cd_rot;
    logic        out_free;
    logic        advance;
    logic        load;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [47:0] m_subkey_reg;
    logic [3:0]  m_round_reg;
    logic        m_last_reg;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = busy_reg && out_free;
    assign load     = q_valid && (!busy_reg || (advance && round_reg == LastRound));
    assign q_ready  = !busy_reg || (advance && round_reg == LastRound);

    // Rotate both halves for the current round
    always_comb begin
        cd_rot.c = rot_half(cd_reg.c, rot_by_two(round_reg));
        cd_rot.d = rot_half(cd_reg.d, rot_by_two(round_reg));
    end

    always_comb begin
        busy_next  = busy_reg;
        round_next = round_reg;
        if (load) begin
            busy_next  = 1'b1;
            round_next = 4'd0;
        end else if (advance) begin
            round_next = round_reg + 4'd1;
            if (round_reg == LastRound) begin
                busy_next  = 1'b0;
                round_next = 4'd0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            round_reg   <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the halves; load a new key or step one round
    always_ff @(posedge aclk) begin
        if (load) begin
            cd_reg <= q_cd;
        end else if (advance) begin
            cd_reg <= cd_rot;
        end
    end

    // Register the subkey beat
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_subkey_reg <= pc2(cd_rot);
            m_round_reg  <= round_reg;
            m_last_reg   <= (round_reg == LastRound);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_subkey      = m_subkey_reg;
    assign m_round_index = m_round_reg;
    assign m_last        = m_last_reg;

    `DKS_ASSERT_SAME(a_idle_round_zero, aclk, aresetn, !busy_reg, round_reg == 4'd0, "round counter moved while idle")
    `DKS_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_valid_reg && m_ready && !m_last_reg, m_valid_reg, "subkey run broke before last round")
    `DKS_ASSERT_NEXT(a_round_steps, aclk, aresetn, m_valid_reg && m_ready && !m_last_reg, m_round_reg == 4'($past(m_round_reg) + 4'd1), "round index skipped")
    `DKS_ASSERT_SAME(a_last_is_final, aclk, aresetn, m_valid_reg, m_last_reg == (m_round_reg == LastRound), "last flag off the final round")

endmodule

FILE: sv/des_key_schedule.sv
`timescale 1ns / 1ps
// DES key schedule: one 64-bit key in, sixteen 48-bit subkey beats out.
// Path: an accepted key passes the PC-1 register, the two-entry queue and
// the C/D register. Throughput: one subkey per cycle while m_ready allows,
// set by the single round sequencer that steps C and D once per subkey.
// Reset: synchronous, active-low aresetn empties the front stage and queue
// and returns the round sequencer to idle.

module des_key_schedule (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_subkey,
    output logic [3:0]  m_round_index,
    output logic        m_last
);
    import dks_pkg::*;

    logic push_valid;
    logic push_ready;
    cd_t  push_cd;
    logic q_valid;
    logic q_ready;
    cd_t  q_cd;

    dks_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key      (s_key),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cd    (push_cd)
    );

    dks_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cd     (push_cd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cd    (q_cd)
    );

    dks_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cd          (q_cd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_subkey      (m_subkey),
        .m_round_index (m_round_index),
        .m_last        (m_last)
    );

endmodule

FILE: verif/tb_des_key_schedule.sv
`timescale 1ns / 1ps

module tb_des_key_schedule;

    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 24;
    localparam int unsigned KeysPerPhase = 88;
    localparam logic [3:0]  FinalRound  = 4'd15;
    localparam logic [63:0] KeyParityBits = 64'h0101_0101_0101_0101;

    // Published DES selections, position 1 is the MSB
    localparam int unsigned Pc1Pick [56] = '{
        57, 49, 41, 33, 25, 17, 9,
        1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27,
        19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,
        7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29,
        21, 13, 5, 28, 20, 12, 4
    };

    localparam int unsigned Pc2Pick [48] = '{
        14, 17, 11, 24, 1, 5,
        3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8,
        16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55,
        30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53,
        46, 42, 50, 36, 29, 32
    };

    localparam int unsigned RotAmount [16] = '{
        1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1
    };

    typedef struct packed {
        logic [47:0] subkey;
        logic [3:0]  round_index;
        logic        last;
    } subkey_beat_t;

    // One directed key; typed rows carry the subkey shared by all sixteen rounds
    typedef struct {
        logic [63:0] key;
        bit          typed;
        logic [47:0] subkey;
    } key_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [63:0] s_key         = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [47:0] m_subkey;
    logic [3:0]  m_round_index;
    logic        m_last;

    subkey_beat_t pending_subkeys[$];
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    int unsigned  send_idle_pct = 22;
    int unsigned  recv_idle_pct = 69;

    des_key_schedule dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_subkey      (m_subkey),
        .m_round_index (m_round_index),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Expand one key into its sixteen round subkeys and queue them
    function automatic void schedule_key(input logic [63:0] key);
        logic [63:0]  k;
        logic [55:0]  cd;
        logic [27:0]  c;
        logic [27:0]  d;
        subkey_beat_t beat;
        k = key & ~KeyParityBits;
        for (int i = 0; i < 56; i++) begin
            cd[55-i] = k[64-Pc1Pick[i]];
        end
        c = cd[55:28];
        d = cd[27:0];
        for (int r = 0; r < 16; r++) begin
            c = (c << RotAmount[r]) | (c >> (28 - RotAmount[r]));
            d = (d << RotAmount[r]) | (d >> (28 - RotAmount[r]));
            cd = {c, d};
            for (int i = 0; i < 48; i++) begin
                beat.subkey[47-i] = cd[56-Pc2Pick[i]];
            end
            beat.round_index = r[3:0];
            beat.last        = (r[3:0] == FinalRound);
            pending_subkeys.push_back(beat);
        end
    endfunction

    // Queue sixteen beats that all carry the same typed subkey
    function automatic void queue_typed(input logic [47:0] subkey);
        subkey_beat_t beat;
        for (int r = 0; r < 16; r++) begin
            beat.subkey      = subkey;
            beat.round_index = r[3:0];
            beat.last        = (r[3:0] == FinalRound);
            pending_subkeys.push_back(beat);
        end
    endfunction

    // Offer one key beat, hold it until accepted; valid stays high for a back-to-back key
    task automatic send_key(input logic [63:0] key, input bit typed, input logic [47:0] subkey);
        int unsigned gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
        if (typed) queue_typed(subkey);
        else schedule_key(key);
    endtask

    // Drop valid and hold off until every queued subkey has come back
    task automatic drain_pending();
        s_valid <= 1'b0;
        while (pending_subkeys.size() != 0) @(posedge aclk);
    endtask

    // Randomize the result side, ready low during reset
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each accepted subkey beat against the oldest expectation
    always @(posedge aclk) begin
        subkey_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_subkeys.size() == 0) begin
                report_mismatch("unexpected beat", {16'h0, m_subkey}, '0);
            end else begin
                want = pending_subkeys.pop_front();
                if (m_subkey !== want.subkey)
                    report_mismatch("subkey", {16'h0, m_subkey}, {16'h0, want.subkey});
                if (m_round_index !== want.round_index)
                    report_mismatch("round_index", {60'h0, m_round_index},
                                    {60'h0, want.round_index});
                if (m_last !== want.last)
                    report_mismatch("last", {63'h0, m_last}, {63'h0, want.last});
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d beats pending", cycle_count,
                     pending_subkeys.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        key_row_t    rows[$];
        logic [63:0] key;
        int unsigned pick;

        rows = '{
            '{64'h0000_0000_0000_0000, 1'b1, 48'h0000_0000_0000},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF},
            '{64'h0101_0101_0101_0101, 1'b1, 48'h0000_0000_0000},
            '{64'hFEFE_FEFE_FEFE_FEFE, 1'b1, 48'hFFFF_FFFF_FFFF},
            '{64'h0000_0000_0000_0001, 1'b1, 48'h0000_0000_0000},
            '{64'h8000_0000_0000_0000, 1'b0, 48'h0},
            '{64'h0000_0000_0000_0002, 1'b0, 48'h0},
            '{64'h1334_5779_9BBC_DFF1, 1'b0, 48'h0},
            '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 48'h0},
            '{64'h5555_5555_5555_5555, 1'b0, 48'h0},
            '{64'h1F1F_1F1F_0E0E_0E0E, 1'b0, 48'h0},
            '{64'hE0E0_E0E0_F1F1_F1F1, 1'b0, 48'h0},
            '{64'h01FE_01FE_01FE_01FE, 1'b0, 48'h0},
            '{64'h0123_4567_89AB_CDEF, 1'b0, 48'h0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed keys: extremes, parity-only, weak and known keys
        foreach (rows[i]) send_key(rows[i].key, rows[i].typed, rows[i].subkey);
        drain_pending();

        // Random keys over three idle profiles, pausing for a full drain midway
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 22; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < KeysPerPhase; n++) begin
                pick = $urandom_range(9);
                key  = {$urandom, $urandom};
                if (pick == 0) key = 64'h1 << $urandom_range(63);
                else if (pick == 1) key = ~(64'h1 << $urandom_range(63));
                else if (pick == 2) key = key ^ KeyParityBits;
                send_key(key, 1'b0, 48'h0);
                if (n == KeysPerPhase / 2) drain_pending();
            end
        end

        s_valid <= 1'b0;
        while (pending_subkeys.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/dks_pkg.sv
sv/dks_front.sv
sv/dks_queue.sv
sv/dks_back.sv
sv/des_key_schedule.sv
verif/tb_des_key_schedule.sv
